FILE: hdl/bibs_pkg.sv
`timescale 1ns / 1ps

package bibs_pkg;

    localparam int DEF_STORE_BYTES = 512;

    // Field and register widths
    localparam int DATA_SIZE_W = 10;
    localparam int INDEX_W     = 9;
    localparam int BYTE_W      = 8;

    // Modular reducer: operand bits walked MSB first, residue width
    localparam int OPND_W = 12;
    localparam int CNT_W  = $clog2(OPND_W);
    localparam int MOD_W  = 13;

    // Step table
    localparam int STEP_COUNT = 171;
    localparam int STEP_IDX_W = $clog2(STEP_COUNT);
    localparam int STEP_W     = 12;

    // size / 3 as (size * DIV3_MUL) >> DIV3_SHIFT, exact for sizes below 1024
    localparam int DIV3_MUL   = 683;
    localparam int DIV3_SHIFT = 11;
    localparam int DIV3_PROD_W = DATA_SIZE_W + 10;

    typedef enum logic [1:0] {
        OP_IWR = 2'd0,
        OP_IRD = 2'd1,
        OP_RWR = 2'd2,
        OP_RRD = 2'd3
    } t_op;

    typedef struct packed {
        logic              start;
        logic [OPND_W-1:0] operand;
        logic [MOD_W-1:0]  addend;
        logic [MOD_W-1:0]  modulus;
    } t_mod_req;

    typedef struct packed {
        logic             done;
        logic [MOD_W-1:0] result;
    } t_mod_rsp;

    localparam logic [STEP_W-1:0] STEP_TABLE [0:STEP_COUNT-1] = '{
        12'd0,    12'd7,    12'd11,   12'd11,   12'd61,   12'd19,   12'd17,   12'd65,
        12'd139,  12'd23,   12'd23,   12'd23,   12'd23,   12'd25,   12'd73,   12'd29,
        12'd31,   12'd97,   12'd77,   12'd53,   12'd31,   12'd79,   12'd223,  12'd59,
        12'd35,   12'd107,  12'd395,  12'd35,   12'd107,  12'd109,  12'd109,  12'd349,
        12'd101,  12'd43,   12'd259,  12'd41,   12'd365,  12'd521,  12'd245,  12'd691,
        12'd403,  12'd355,  12'd47,   12'd247,  12'd47,   12'd187,  12'd47,   12'd131,
        12'd47,   12'd95,   12'd49,   12'd97,   12'd145,  12'd457,  12'd53,   12'd977,
        12'd55,   12'd439,  12'd97,   12'd245,  12'd437,  12'd317,  12'd461,  12'd55,
        12'd199,  12'd1207, 12'd103,  12'd103,  12'd395,  12'd515,  12'd59,   12'd329,
        12'd137,  12'd227,  12'd491,  12'd59,   12'd269,  12'd299,  12'd301,  12'd229,
        12'd181,  12'd133,  12'd253,  12'd205,  12'd277,  12'd67,   12'd667,  12'd283,
        12'd65,   12'd245,  12'd1193, 12'd473,  12'd593,  12'd293,  12'd1675, 12'd1603,
        12'd499,  12'd1651, 12'd1291, 12'd71,   12'd247,  12'd215,  12'd71,   12'd335,
        12'd215,  12'd71,   12'd551,  12'd563,  12'd71,   12'd599,  12'd1031, 12'd73,
        12'd1501, 12'd253,  12'd217,  12'd217,  12'd601,  12'd77,   12'd841,  12'd445,
        12'd79,   12'd271,  12'd553,  12'd145,  12'd509,  12'd893,  12'd1181, 12'd173,
        12'd149,  12'd605,  12'd79,   12'd511,  12'd427,  12'd283,  12'd175,  12'd439,
        12'd151,  12'd803,  12'd155,  12'd1171, 12'd83,   12'd1337, 12'd635,  12'd587,
        12'd2171, 12'd2123, 12'd299,  12'd83,   12'd827,  12'd317,  12'd283,  12'd589,
        12'd373,  12'd805,  12'd421,  12'd727,  12'd823,  12'd1837, 12'd485,  12'd709,
        12'd269,  12'd421,  12'd715,  12'd181,  12'd349,  12'd89,   12'd557,  12'd737,
        12'd317,  12'd605,  12'd869
    };

    // Step for an effective packet size; indexes past the table end use the last entry
    function automatic logic [STEP_W-1:0] step_for_size(input logic [DATA_SIZE_W-1:0] size);
        logic [DIV3_PROD_W-1:0] prod;
        logic [DIV3_PROD_W-1:0] third;
        logic [STEP_IDX_W-1:0]  idx;
        prod  = DIV3_PROD_W'(size) * DIV3_PROD_W'(DIV3_MUL);
        third = prod >> DIV3_SHIFT;
        if (third >= DIV3_PROD_W'(STEP_COUNT - 1)) begin
            idx = STEP_IDX_W'(STEP_COUNT - 1);
        end else begin
            idx = third[STEP_IDX_W-1:0];
        end
        return STEP_TABLE[idx];
    endfunction

endpackage

FILE: hdl/bit_interleaved_byte_store_top.sv
// Transactions are taken one at a time; input is accepted only in the idle state.
// Interleaved: a 12-step bit-serial modular reducer finds the first bit position, then
// eight bit accesses; raw: a reciprocal address reduction, then one access.
// Reset (synchronous, active low) sets data_size to 1; after reset and after every
// data_size write, input is held off while the step residue is computed.
`timescale 1ns / 1ps

module bit_interleaved_byte_store_top #(
    parameter int STORE_BYTES = bibs_pkg::DEF_STORE_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // Input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // [8:0] byte_index, [16:9] write_data, rest zero
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] operation

    // Result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [7:0] read_data

    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    import bibs_pkg::*;

    localparam int AW = $clog2(STORE_BYTES);

    // Raw address = index - q * STORE_BYTES, q taken from a reciprocal multiply
    // that is exact for every 9-bit index
    localparam int RAW_SH     = INDEX_W + $clog2(STORE_BYTES);
    localparam int RAW_RCP    = ((1 << RAW_SH) + STORE_BYTES - 1) / STORE_BYTES;
    localparam int RAW_PROD_W = 2 * INDEX_W + 2;
    localparam int RAW_BACK_W = INDEX_W + MOD_W;

    // Register index is the word address
    localparam logic REG_DATA_SIZE = 1'b0;

    typedef enum logic [3:0] {
        S_PREP,     // latch modulus, start step residue
        S_SETUP,    // wait for step mod modulus
        S_IDLE,     // take a transaction
        S_POS,      // wait for first bit position
        S_RADDR,    // reduce the raw address into the store
        S_ACC,      // issue the eight bit accesses
        S_LAST,     // finish the eighth access
        S_RAW,      // raw write, or issue raw read
        S_RAWRD,    // capture raw read data
        S_RES       // hand the byte to the output register
    } t_state;

    t_state                r_state;
    logic [DATA_SIZE_W-1:0] r_data_size;
    logic [MOD_W-1:0]      r_modulus;
    logic [MOD_W-1:0]      r_step_mod;
    t_op                   r_op;
    logic [BYTE_W-1:0]     r_wdata;
    logic [MOD_W-1:0]      r_pos;
    logic [2:0]            r_k;
    logic [INDEX_W-1:0]    r_raw_idx;
    logic [INDEX_W-1:0]    r_raw_quot;

    // Access pipeline stage (read data returns here)
    logic                  r_s1_valid;
    logic [AW-1:0]         r_s1_addr;
    logic [2:0]            r_s1_bit;
    logic [2:0]            r_s1_k;

    // Last byte written by the pipeline, forwarded past the RAM read latency
    logic                  r_fwd_valid;
    logic [AW-1:0]         r_fwd_addr;
    logic [BYTE_W-1:0]     r_fwd_data;

    logic [BYTE_W-1:0]     r_gather;
    logic                  r_out_valid;
    logic [BYTE_W-1:0]     r_out_data;

    logic                  in_accept;
    logic                  cfg_write;
    logic                  out_free;
    logic [DATA_SIZE_W-1:0] eff_size;
    logic [MOD_W-1:0]      prep_modulus;
    logic [MOD_W:0]        pos_sum;
    logic [MOD_W-1:0]      n_pos;
    logic [31:0]           pos_byte_w;
    logic [31:0]           raw_w;
    logic [AW-1:0]         pos_addr;
    logic [AW-1:0]         raw_addr;
    logic [RAW_PROD_W-1:0] raw_prod;
    logic [INDEX_W-1:0]    raw_quot;
    logic [RAW_BACK_W-1:0] raw_back;
    logic [MOD_W-1:0]      n_raw_pos;
    logic [BYTE_W-1:0]     ram_rdata;
    logic [BYTE_W-1:0]     s1_byte;
    logic [BYTE_W-1:0]     n_byte;
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [BYTE_W-1:0]     ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [INDEX_W-1:0]    in_index;
    logic [BYTE_W-1:0]     in_wdata;
    t_op                   in_op;
    t_mod_req              mod_req;
    t_mod_rsp              mod_rsp;

    // ------------------------------------------------------------------
    // Handshakes and configuration port
    // ------------------------------------------------------------------
    assign in_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_DATA_SIZE);
    assign out_free  = !r_out_valid || i_m_axis_tready;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign pready          = 1'b1;
    assign prdata          = (paddr[2] == REG_DATA_SIZE) ? 32'(r_data_size) : '0;

    assign in_index = i_s_axis_tdata[INDEX_W-1:0];
    assign in_wdata = i_s_axis_tdata[INDEX_W+BYTE_W-1:INDEX_W];
    assign in_op    = t_op'(i_s_axis_tuser);

    // ------------------------------------------------------------------
    // Effective size: zero acts as one, clamp to the store
    // ------------------------------------------------------------------
    always_comb begin
        if (r_data_size == '0) begin
            eff_size = DATA_SIZE_W'(1);
        end else if (32'(r_data_size) > STORE_BYTES) begin
            eff_size = DATA_SIZE_W'(STORE_BYTES);
        end else begin
            eff_size = r_data_size;
        end
        prep_modulus = {eff_size, 3'b000};
    end

    // ------------------------------------------------------------------
    // Reducer requests: step residue during setup, otherwise the item's start point.
    // Interleaved: first bit position = (8 * index * step) mod (8 * size).
    // ------------------------------------------------------------------
    always_comb begin
        if (r_state == S_PREP) begin
            mod_req.start   = 1'b1;
            mod_req.operand = OPND_W'(step_for_size(eff_size));
            mod_req.addend  = MOD_W'(1);
            mod_req.modulus = prep_modulus;
        end else begin
            mod_req.start   = in_accept && (in_op == OP_IWR || in_op == OP_IRD);
            mod_req.operand = {in_index, 3'b000};
            mod_req.addend  = r_step_mod;
            mod_req.modulus = r_modulus;
        end
    end

    bibs_mod_unit u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mod_req),
        .o_rsp   (mod_rsp)
    );

    // ------------------------------------------------------------------
    // Raw address: quotient on accept, remainder in S_RADDR in the cycle after, never later
    // ------------------------------------------------------------------
    always_comb begin
        raw_prod  = RAW_PROD_W'(in_index) * RAW_PROD_W'(RAW_RCP);
        raw_quot  = INDEX_W'(raw_prod >> RAW_SH);
        raw_back  = RAW_BACK_W'(r_raw_idx)
                  - RAW_BACK_W'(r_raw_quot) * RAW_BACK_W'(STORE_BYTES);
        n_raw_pos = raw_back[MOD_W-1:0];
    end

    // ------------------------------------------------------------------
    // Bit position walk: advance by the step residue, wrap at the modulus
    // ------------------------------------------------------------------
    always_comb begin
        pos_sum = {1'b0, r_pos} + {1'b0, r_step_mod};
        if (pos_sum >= {1'b0, r_modulus}) begin
            n_pos = MOD_W'(pos_sum - {1'b0, r_modulus});
        end else begin
            n_pos = pos_sum[MOD_W-1:0];
        end
        pos_byte_w = 32'(r_pos[MOD_W-1:3]);
        raw_w      = 32'(r_pos);
        pos_addr   = pos_byte_w[AW-1:0];
        raw_addr   = raw_w[AW-1:0];
    end

    // ------------------------------------------------------------------
    // Read-modify-write on the returned byte; forward the byte written in the previous
    // cycle when the same entry comes back, since the RAM read saw the old value
    // ------------------------------------------------------------------
    always_comb begin
        if (r_fwd_valid && (r_fwd_addr == r_s1_addr)) begin
            s1_byte = r_fwd_data;
        end else begin
            s1_byte = ram_rdata;
        end
        n_byte           = s1_byte;
        n_byte[r_s1_bit] = r_wdata[r_s1_k];

        if (r_state == S_RAW) begin
            ram_we    = (r_op == OP_RWR);
            ram_waddr = raw_addr;
            ram_wdata = r_wdata;
        end else begin
            ram_we    = r_s1_valid && (r_op == OP_IWR);
            ram_waddr = r_s1_addr;
            ram_wdata = n_byte;
        end
        ram_raddr = (r_state == S_ACC) ? pos_addr : raw_addr;
    end

    bibs_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (STORE_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Sequencer, access pipeline and output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_PREP;
            r_data_size <= DATA_SIZE_W'(1);
            r_s1_valid  <= 1'b0;
            r_fwd_valid <= 1'b0;
            r_out_valid <= 1'b0;
            r_k         <= '0;
        end else begin
            // Stage 1: gather the bit and record the write for forwarding
            r_s1_valid  <= 1'b0;
            r_fwd_valid <= r_s1_valid && (r_op == OP_IWR);
            r_fwd_addr  <= r_s1_addr;
            r_fwd_data  <= n_byte;
            if (r_s1_valid) begin
                r_gather[r_s1_k] <= s1_byte[r_s1_bit];
            end

            // Drop the result once taken
            if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_PREP: begin
                    r_modulus <= prep_modulus;
                    r_state   <= S_SETUP;
                end
                S_SETUP: begin
                    if (mod_rsp.done) begin
                        r_step_mod <= mod_rsp.result;
                        r_state    <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_accept) begin
                        r_op       <= in_op;
                        r_wdata    <= in_wdata;
                        r_raw_idx  <= in_index;
                        r_raw_quot <= raw_quot;
                        if (in_op == OP_RWR || in_op == OP_RRD) begin
                            r_state <= S_RADDR;
                        end else begin
                            r_state <= S_POS;
                        end
                    end
                end
                S_POS: begin
                    if (mod_rsp.done) begin
                        r_pos   <= mod_rsp.result;
                        r_k     <= '0;
                        r_state <= S_ACC;
                    end
                end
                S_RADDR: begin
                    r_pos   <= n_raw_pos;
                    r_state <= S_RAW;
                end
                S_ACC: begin
                    r_s1_valid <= 1'b1;
                    r_s1_addr  <= pos_addr;
                    r_s1_bit   <= r_pos[2:0];
                    r_s1_k     <= r_k;
                    r_pos      <= n_pos;
                    r_k        <= r_k + 1'b1;
                    if (r_k == 3'd7) begin
                        r_state <= S_LAST;
                    end
                end
                S_LAST: begin
                    r_state <= (r_op == OP_IRD) ? S_RES : S_IDLE;
                end
                S_RAW: begin
                    r_state <= (r_op == OP_RRD) ? S_RAWRD : S_IDLE;
                end
                S_RAWRD: begin
                    r_gather <= ram_rdata;
                    r_state  <= S_RES;
                end
                S_RES: begin
                    // Hold until the output register frees up
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= r_gather;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_PREP;
                end
            endcase

            // A size change recomputes modulus and step residue
            if (cfg_write) begin
                r_data_size <= pwdata[DATA_SIZE_W-1:0];
                r_state     <= S_PREP;
            end
        end
    end

`ifndef SYNTHESIS
    a_pos_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACC) |-> (r_pos < r_modulus))
        else $error("bit position outside packet");

    a_step_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_step_mod < r_modulus))
        else $error("step residue not reduced");

    a_raw_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RAW) |-> (32'(r_pos) < STORE_BYTES))
        else $error("raw address beyond store");

    a_write_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_op == OP_IWR || r_op == OP_RWR))
        else $error("store written on a read transaction");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> ((r_state == S_POS || r_state == S_RADDR) && mod_rsp.done == 1'b0))
        else $error("transaction accepted while reducer busy");
`endif

endmodule

FILE: hdl/bibs_ram.sv
`timescale 1ns / 1ps

module bibs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/bibs_mod_unit.sv
`timescale 1ns / 1ps

// Horner reduction: result = (operand * addend) mod modulus, one operand bit per cycle.
// Requires addend < modulus.
module bibs_mod_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bibs_pkg::t_mod_req i_req,
    output bibs_pkg::t_mod_rsp o_rsp
);

    import bibs_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [OPND_W-1:0] r_opnd;
    logic [MOD_W-1:0]  r_add;
    logic [MOD_W-1:0]  r_mod;
    logic [MOD_W-1:0]  r_acc;

    logic [MOD_W+1:0]  sum;
    logic [MOD_W+1:0]  mod_x1;
    logic [MOD_W+1:0]  mod_x2;
    logic [MOD_W-1:0]  n_acc;

    // double, add, then fold back below the modulus (sum < 3 * modulus)
    always_comb begin
        sum    = {1'b0, r_acc, 1'b0} + (r_opnd[OPND_W-1] ? (MOD_W+2)'(r_add) : '0);
        mod_x1 = (MOD_W+2)'(r_mod);
        mod_x2 = {1'b0, r_mod, 1'b0};
        if (sum >= mod_x2) begin
            n_acc = MOD_W'(sum - mod_x2);
        end else if (sum >= mod_x1) begin
            n_acc = MOD_W'(sum - mod_x1);
        end else begin
            n_acc = sum[MOD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_opnd <= i_req.operand;
                r_add  <= i_req.addend;
                r_mod  <= i_req.modulus;
                r_acc  <= '0;
            end else if (r_busy) begin
                r_acc  <= n_acc;
                r_opnd <= {r_opnd[OPND_W-2:0], 1'b0};
                r_cnt  <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(OPND_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_acc;

`ifndef SYNTHESIS
    a_acc_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_acc < r_mod)
        else $error("residue not below modulus");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("done held more than one cycle");

    a_busy_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("done while still iterating");
`endif

endmodule

FILE: bench/tb_bit_interleaved_byte_store_top.sv
`timescale 1ns / 1ps

module tb_bit_interleaved_byte_store_top;

    import bibs_pkg::*;

    localparam int STORE = DEF_STORE_BYTES;

    // Register map: data_size is the only register, the next word is unmapped
    localparam logic [2:0] REG_DATA_SIZE = 3'd0;
    localparam logic [2:0] REG_UNMAPPED  = 3'd4;

    // Cycles to let pass after the last result before touching the register
    // (an interleaved write can still be scattering its bits)
    localparam int SETTLE_CYCLES = 40;
    // Cycles without any transaction before the run is declared hung
    localparam int HANG_LIMIT    = 5000;
    // Length of the long result-side hold-off
    localparam int LONG_HOLD     = 300;
    localparam int PHASE_ITEMS   = 65;
    localparam int HOLD_PHASE    = 5;

    // Step per size / 3, last entry used past the end
    localparam int unsigned STEPS [0:170] = '{
        0, 7, 11, 11, 61, 19, 17, 65, 139, 23,
        23, 23, 23, 25, 73, 29, 31, 97, 77, 53,
        31, 79, 223, 59, 35, 107, 395, 35, 107, 109,
        109, 349, 101, 43, 259, 41, 365, 521, 245, 691,
        403, 355, 47, 247, 47, 187, 47, 131, 47, 95,
        49, 97, 145, 457, 53, 977, 55, 439, 97, 245,
        437, 317, 461, 55, 199, 1207, 103, 103, 395, 515,
        59, 329, 137, 227, 491, 59, 269, 299, 301, 229,
        181, 133, 253, 205, 277, 67, 667, 283, 65, 245,
        1193, 473, 593, 293, 1675, 1603, 499, 1651, 1291, 71,
        247, 215, 71, 335, 215, 71, 551, 563, 71, 599,
        1031, 73, 1501, 253, 217, 217, 601, 77, 841, 445,
        79, 271, 553, 145, 509, 893, 1181, 173, 149, 605,
        79, 511, 427, 283, 175, 439, 151, 803, 155, 1171,
        83, 1337, 635, 587, 2171, 2123, 299, 83, 827, 317,
        283, 589, 373, 805, 421, 727, 823, 1837, 485, 709,
        269, 421, 715, 181, 349, 89, 557, 737, 317, 605,
        869
    };

    // Sizes walked by the random phases; extremes and odd sizes included
    localparam int N_SIZES = 18;
    localparam logic [9:0] PHASE_SIZES [0:N_SIZES-1] = '{
        10'd1, 10'd2, 10'd0, 10'd3, 10'd4, 10'd5, 10'd512, 10'd1023, 10'd513,
        10'd7, 10'd100, 10'd170, 10'd255, 10'd256, 10'd301, 10'd384, 10'd500, 10'd511
    };

    typedef enum logic [1:0] {
        IDLE_NONE = 2'd0,
        IDLE_TX   = 2'd1,
        IDLE_RX   = 2'd2,
        IDLE_BOTH = 2'd3
    } t_idling;

    typedef struct packed {
        t_op        op;
        logic [8:0] idx;
        logic [7:0] value;
    } t_byte_expect;

    typedef struct packed {
        logic [9:0] size;
        t_op        op;
        logic [8:0] idx;
        logic [7:0] wdata;
        logic       typed;
        logic [7:0] want;
    } t_dir_row;

    // Directed stimulus; a row with typed set carries its own read-back value
    localparam int N_DIR = 23;
    localparam t_dir_row DIR_ROWS [0:N_DIR-1] = '{
        // size 1: step 0, every bit lands on raw bit 0, the last bit wins
        '{10'd1,    OP_IWR, 9'd0,   8'h80, 1'b0, 8'h00},
        '{10'd1,    OP_IRD, 9'd0,   8'h00, 1'b1, 8'hFF},
        '{10'd1,    OP_IWR, 9'd511, 8'h7F, 1'b0, 8'h00},
        '{10'd1,    OP_IRD, 9'd300, 8'hFF, 1'b1, 8'h00},
        '{10'd1,    OP_RWR, 9'd0,   8'hA5, 1'b0, 8'h00},
        '{10'd1,    OP_RRD, 9'd0,   8'h00, 1'b1, 8'hA5},
        '{10'd1,    OP_RWR, 9'd511, 8'h5A, 1'b0, 8'h00},
        '{10'd1,    OP_RRD, 9'd511, 8'h00, 1'b1, 8'h5A},
        // zero size behaves as size 1
        '{10'd0,    OP_IRD, 9'd5,   8'h00, 1'b1, 8'hFF},
        // size 2 still uses step 0
        '{10'd2,    OP_IWR, 9'd1,   8'h01, 1'b0, 8'h00},
        '{10'd2,    OP_IRD, 9'd0,   8'h00, 1'b1, 8'h00},
        // size 3: step 7 over 24 bits, a full permutation of bytes 0..2
        '{10'd3,    OP_IWR, 9'd0,   8'h00, 1'b0, 8'h00},
        '{10'd3,    OP_IWR, 9'd1,   8'hFF, 1'b0, 8'h00},
        '{10'd3,    OP_IWR, 9'd2,   8'h3C, 1'b0, 8'h00},
        '{10'd3,    OP_IRD, 9'd1,   8'h00, 1'b0, 8'h00},
        '{10'd3,    OP_IRD, 9'd2,   8'h00, 1'b0, 8'h00},
        '{10'd3,    OP_RRD, 9'd1,   8'h00, 1'b0, 8'h00},
        // oversize clamps to the full store and the last step
        '{10'd513,  OP_IWR, 9'd511, 8'hFF, 1'b0, 8'h00},
        '{10'd513,  OP_IRD, 9'd511, 8'h00, 1'b1, 8'hFF},
        '{10'd513,  OP_IWR, 9'd0,   8'h00, 1'b0, 8'h00},
        '{10'd513,  OP_IRD, 9'd0,   8'hFF, 1'b1, 8'h00},
        '{10'd1023, OP_IRD, 9'd511, 8'h00, 1'b1, 8'hFF},
        '{10'd512,  OP_RRD, 9'd511, 8'h00, 1'b0, 8'h00}
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [23:0] i_s_axis_tdata;   // [8:0] byte_index, [16:9] write_data, rest zero
    logic [1:0]  i_s_axis_tuser;   // [1:0] operation
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [7:0]  o_m_axis_tdata;   // [7:0] read_data
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Shadow of the packet store and of data_size
    logic [7:0]   pkt_shadow [0:STORE-1];
    logic [9:0]   size_reg;
    t_byte_expect pending_bytes [$];

    int unsigned  tx_idle_pct;
    int unsigned  rx_stall_pct;
    int           rx_hold_req;
    int           mismatches;

    bit_interleaved_byte_store_top #(
        .STORE_BYTES (STORE)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // Prediction
    // ---------------------------------------------------------------

    // Packet length in effect: zero acts as one, oversize clamps to the store
    function automatic int unsigned live_size();
        int unsigned s;
        s = size_reg;
        if (s == 0) s = 1;
        if (s > STORE) s = STORE;
        return s;
    endfunction

    // Raw bit position of a logical bit; the product is taken at full width
    function automatic int unsigned scatter_pos(input int unsigned logical_bit);
        int unsigned s;
        int unsigned t;
        s = live_size();
        t = s / 3;
        if (t > 170) t = 170;
        return (logical_bit * STEPS[t]) % (s * 8);
    endfunction

    // Apply one transaction to the shadow store; return the byte a read yields
    function automatic bit store_access(input t_op op, input logic [8:0] idx,
                                        input logic [7:0] wdata, output logic [7:0] rdata);
        int unsigned p;
        int unsigned b;
        rdata = 8'h00;
        case (op)
            OP_IWR: begin
                // scatter bits in order so a colliding later bit wins
                for (int k = 0; k < 8; k++) begin
                    p = scatter_pos(idx * 8 + k);
                    b = (p >> 3) % STORE;
                    pkt_shadow[b][p % 8] = wdata[k];
                end
                return 1'b0;
            end
            OP_IRD: begin
                for (int k = 0; k < 8; k++) begin
                    p = scatter_pos(idx * 8 + k);
                    b = (p >> 3) % STORE;
                    rdata[k] = pkt_shadow[b][p % 8];
                end
                return 1'b1;
            end
            OP_RWR: begin
                pkt_shadow[idx % STORE] = wdata;
                return 1'b0;
            end
            default: begin
                rdata = pkt_shadow[idx % STORE];
                return 1'b1;
            end
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Input side
    // ---------------------------------------------------------------

    // Offer one transaction, idling at random first; hold it until accepted,
    // then fold it into the shadow store and queue the byte a read returns
    task automatic offer(input t_op op, input logic [8:0] idx, input logic [7:0] wdata,
                         input logic typed, input logic [7:0] want);
        logic [7:0]   got;
        t_byte_expect e;
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata  = {7'd0, wdata, idx};
        i_s_axis_tuser  = op;
        do @(posedge i_clk); while (!o_s_axis_tready);
        if (store_access(op, idx, wdata, got)) begin
            e.op    = op;
            e.idx   = idx;
            e.value = typed ? want : got;
            pending_bytes.push_back(e);
        end
    endtask

    // Drop valid and wait until every queued byte has come back, then let the
    // block finish any write it may still be scattering
    task automatic drain();
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        while (pending_bytes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------
    // Configuration port
    // ---------------------------------------------------------------

    task automatic cfg_write(input logic [2:0] addr, input logic [31:0] data);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Read data_size back and compare with the shadow value
    task automatic cfg_check();
        logic [31:0] got;
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = REG_DATA_SIZE;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        if (got !== {22'd0, size_reg}) begin
            $display("%0t: data_size read-back mismatch: expected %0d, actual %0d",
                     $time, size_reg, got);
            mismatches++;
        end
    endtask

    // Change the packet length only with the block idle
    task automatic resize(input logic [9:0] sz);
        drain();
        cfg_write(REG_DATA_SIZE, {22'd0, sz});
        size_reg = sz;
        cfg_check();
    endtask

    task automatic set_idling(input t_idling mode);
        case (mode)
            IDLE_NONE: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
            IDLE_TX:   begin tx_idle_pct = 46; rx_stall_pct = 0;  end
            IDLE_RX:   begin tx_idle_pct = 0;  rx_stall_pct = 46; end
            default:   begin tx_idle_pct = 31; rx_stall_pct = 31; end
        endcase
    endtask

    // ---------------------------------------------------------------
    // Random traffic
    // ---------------------------------------------------------------

    // Mostly indexes inside the packet, sometimes anywhere in the field
    function automatic logic [8:0] pick_index();
        if ($urandom_range(99) < 75) return 9'($urandom_range(live_size() - 1));
        return 9'($urandom_range(511));
    endfunction

    // One burst: write-then-read pairs make up half of the bursts, single accesses the rest
    task automatic random_burst(inout int sent);
        int unsigned pick;
        logic [8:0]  ix;
        pick = $urandom_range(99);
        ix   = pick_index();
        if (pick < 35) begin
            offer(OP_IWR, ix, 8'($urandom), 1'b0, 8'h00);
            offer(OP_IRD, ix, 8'($urandom), 1'b0, 8'h00);
            sent += 2;
        end else if (pick < 50) begin
            offer(OP_IRD, ix, 8'($urandom), 1'b0, 8'h00);
            sent += 1;
        end else if (pick < 60) begin
            offer(OP_IWR, ix, 8'($urandom), 1'b0, 8'h00);
            sent += 1;
        end else if (pick < 75) begin
            offer(OP_RWR, ix, 8'($urandom), 1'b0, 8'h00);
            offer(OP_RRD, ix, 8'($urandom), 1'b0, 8'h00);
            sent += 2;
        end else if (pick < 88) begin
            offer(OP_RRD, ix, 8'($urandom), 1'b0, 8'h00);
            sent += 1;
        end else begin
            offer(OP_RWR, ix, 8'($urandom), 1'b0, 8'h00);
            sent += 1;
        end
    endtask

    // ---------------------------------------------------------------
    // Result side: random stalls plus an occasional long hold-off that
    // this process counts out itself
    // ---------------------------------------------------------------
    initial begin : result_sink
        int hold_left;
        hold_left       = 0;
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req > 0) begin
                hold_left   = rx_hold_req;
                rx_hold_req = 0;
            end
            if (hold_left > 0) begin
                i_m_axis_tready = 1'b0;
                hold_left--;
            end else begin
                i_m_axis_tready = ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // Compare each accepted result with the oldest queued byte
    initial begin : result_check
        t_byte_expect e;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
                if (pending_bytes.size() == 0) begin
                    $display("%0t: unexpected result: expected none, actual %02h",
                             $time, o_m_axis_tdata);
                    mismatches++;
                end else begin
                    e = pending_bytes.pop_front();
                    if (o_m_axis_tdata !== e.value) begin
                        $display("%0t: read_data mismatch (%s index %0d): expected %02h, actual %02h",
                                 $time, e.op.name(), e.idx, e.value, o_m_axis_tdata);
                        mismatches++;
                    end
                end
            end
        end
    end

    // Hang detector: count cycles in which neither stream moves a transaction
    initial begin : hang_watch
        int quiet;
        quiet = 0;
        while (quiet < HANG_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("simulation failed");
        $finish;
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin : main_seq
        t_dir_row row;
        logic [9:0] sz;
        int         sent;

        // Drive every input to a known value before the first edge
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = 24'd0;
        i_s_axis_tuser  = OP_IWR;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = REG_DATA_SIZE;
        pwdata          = 32'd0;
        rx_hold_req     = 0;
        mismatches      = 0;
        size_reg        = 10'd1;
        for (int a = 0; a < STORE; a++) pkt_shadow[a] = 8'h00;
        set_idling(IDLE_NONE);

        // Hold reset, then release it on a falling edge
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // data_size comes out of reset as 1; a write to the unmapped word
        // must leave it alone
        cfg_check();
        cfg_write(REG_UNMAPPED, 32'd7);
        cfg_check();

        // Directed rows; resize only when a row asks for another length
        for (int r = 0; r < N_DIR; r++) begin
            row = DIR_ROWS[r];
            if (row.size != size_reg) resize(row.size);
            offer(row.op, row.idx, row.wdata, row.typed, row.want);
        end

        // Fill the whole store with raw writes so no later read can touch an
        // entry that was never written
        set_idling(IDLE_BOTH);
        for (int a = 0; a < STORE; a++) offer(OP_RWR, 9'(a), 8'($urandom), 1'b0, 8'h00);

        // Random phases, each at its own packet length and idling pattern;
        // the last two lengths are picked at random
        for (int ph = 0; ph < N_SIZES + 2; ph++) begin
            sz = (ph < N_SIZES) ? PHASE_SIZES[ph] : 10'($urandom_range(1023));
            resize(sz);
            set_idling(t_idling'(ph % 4));
            if (ph == HOLD_PHASE) begin
                // block the result side for a long stretch while the input
                // keeps offering, so the block backs up into its input
                set_idling(IDLE_NONE);
                rx_hold_req = LONG_HOLD;
            end
            sent = 0;
            while (sent < PHASE_ITEMS) random_burst(sent);
        end

        // Wait out the tail, then report
        drain();
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
hdl/bibs_pkg.sv
hdl/bibs_ram.sv
hdl/bibs_mod_unit.sv
hdl/bit_interleaved_byte_store_top.sv
bench/tb_bit_interleaved_byte_store_top.sv
